// ===== sv/gbw_pkg.sv =====
// ----------------------------------------------------------------------------
// gbw_pkg: shared types and constants for the GIF block walker.
// Holds the request and result payload types, parse phases and block kinds.
// ----------------------------------------------------------------------------
`default_nettype none
package gbw_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int COUNT_BITS  = 16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } gbw_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] frame_number;
        logic [15:0] delay;
        logic        has_control;
        logic [2:0]  disposal;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
        logic [23:0] span_start;
        logic [23:0] span_length;
        logic [23:0] background_rgb;
    } gbw_out_t;

    localparam logic [1:0] KIND_SCREEN = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [3:0] PH_SIG     = 4'd0;
    localparam logic [3:0] PH_LSD     = 4'd1;
    localparam logic [3:0] PH_GCT     = 4'd2;
    localparam logic [3:0] PH_BLOCK   = 4'd3;
    localparam logic [3:0] PH_LABEL   = 4'd4;
    localparam logic [3:0] PH_EXTHDR  = 4'd5;
    localparam logic [3:0] PH_SUBLEN  = 4'd6;
    localparam logic [3:0] PH_SUBDATA = 4'd7;
    localparam logic [3:0] PH_IMGDESC = 4'd8;
    localparam logic [3:0] PH_LCT     = 4'd9;
    localparam logic [3:0] PH_LZW     = 4'd10;
    localparam logic [3:0] PH_DONE    = 4'd11;

    localparam logic [2:0] BK_OTHER     = 3'd0;
    localparam logic [2:0] BK_CTRL_KEEP = 3'd1;
    localparam logic [2:0] BK_CTRL_SKIP = 3'd2;
    localparam logic [2:0] BK_PLAIN     = 3'd3;
    localparam logic [2:0] BK_IMAGE     = 3'd4;

    localparam logic [7:0] INTRO_EXT     = 8'h21;
    localparam logic [7:0] INTRO_IMAGE   = 8'h2C;
    localparam logic [7:0] INTRO_TRAILER = 8'h3B;
    localparam logic [7:0] LABEL_CTRL    = 8'hF9;
    localparam logic [7:0] LABEL_COMMENT = 8'hFE;
    localparam logic [7:0] LABEL_APP     = 8'hFF;
    localparam logic [7:0] LABEL_PLAIN   = 8'h01;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                3'd0:    r = 8'h47;
                3'd1:    r = 8'h49;
                3'd2:    r = 8'h46;
                3'd3:    r = 8'h38;
                3'd4:    r = 8'h37;
                3'd5:    r = 8'h61;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/gbw_stream_if.sv =====
// ----------------------------------------------------------------------------
// gbw_stream_if: valid/ready channels, each carrying one payload.
// gbw_in_if carries the byte requests and gbw_out_if the result requests.
// ----------------------------------------------------------------------------
`default_nettype none
interface gbw_in_if;
    import gbw_pkg::*;
    logic    valid;
    logic    ready;
    gbw_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gbw_out_if;
    import gbw_pkg::*;
    logic     valid;
    logic     ready;
    gbw_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/gbw_out_reg.sv =====
// ----------------------------------------------------------------------------
// gbw_out_reg: result register with skid stage.
// Decouples the parser from back-pressure on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none
module gbw_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire gbw_pkg::gbw_out_t push_data,
    output logic                  can_take,
    gbw_out_if.source             m
);
    import gbw_pkg::*;

    logic     main_v_reg, skid_v_reg;
    gbw_out_t main_d_reg, skid_d_reg;

    // Ready towards the parser depends only on the skid slot being empty.
    assign can_take = !skid_v_reg;
    assign m.valid  = main_v_reg;
    assign m.data   = main_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (!main_v_reg || m.ready)
            begin
                if (skid_v_reg)
                begin
                    main_v_reg <= 1'b1;
                    skid_v_reg <= push;
                end
                else
                begin
                    main_v_reg <= push;
                end
            end
            else if (push)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_v_reg || m.ready)
        begin
            if (skid_v_reg)
            begin
                main_d_reg <= skid_d_reg;
                if (push) skid_d_reg <= push_data;
            end
            else
            begin
                main_d_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_d_reg <= push_data;
        end
    end
endmodule
`default_nettype wire

// ===== sv/gbw_parser.sv =====
// ----------------------------------------------------------------------------
// gbw_parser: the GIF block-structure state machine.
// Advances once per accepted byte and forms at most one result.
// ----------------------------------------------------------------------------
`default_nettype none
module gbw_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire gbw_pkg::gbw_in_t  din,
    input  wire logic [15:0]       min_delay,
    output logic                   res_valid,
    output gbw_pkg::gbw_out_t      res
);
    import gbw_pkg::*;

    logic [3:0]             phase_reg, phase_next;
    logic [9:0]             cnt_reg, cnt_next;
    logic [OFFSET_BITS-1:0] offs_reg, offs_next;
    logic [9:0]             ctb_reg, ctb_next;
    logic [7:0]             bgi_reg, bgi_next;
    logic [23:0]            bgc_reg, bgc_next;
    logic [31:0]            scr_reg, scr_next;
    logic                   pc_reg, pc_next;
    logic [15:0]            pd_reg, pd_next;
    logic [2:0]             pdis_reg, pdis_next;
    logic [63:0]            rect_reg, rect_next;
    logic [OFFSET_BITS-1:0] fs_reg, fs_next;
    logic [COUNT_BITS-1:0]  ft_reg, ft_next;
    logic [7:0]             pf_reg, pf_next;
    logic [2:0]             bk_reg, bk_next;
    logic [OFFSET_BITS-1:0] bs_reg, bs_next;
    logic [3:0]             el_reg, el_next;

    logic [7:0]             b;
    logic [9:0]             cnt_inc;
    logic [OFFSET_BITS-1:0] span_len;
    logic [9:0]             tbl_bytes;
    logic [9:0]             gct_idx3;

    assign b         = din.data_byte;
    assign cnt_inc   = cnt_reg + 10'd1;
    assign span_len  = offs_reg - fs_reg + OFFSET_BITS'(1);
    // 3 << (n+1) for the colour table size carried in the packed byte.
    assign tbl_bytes = 10'(10'd3 << ({1'b0, b[2:0]} + 4'd1));
    // Entry index times three, compared against the running byte count.
    assign gct_idx3  = 10'({2'b0, bgi_reg} * 10'd3);

    always_comb
    begin
        phase_next = phase_reg; cnt_next = cnt_reg; ctb_next = ctb_reg;
        bgi_next = bgi_reg; bgc_next = bgc_reg; scr_next = scr_reg;
        pc_next = pc_reg; pd_next = pd_reg; pdis_next = pdis_reg;
        rect_next = rect_reg; fs_next = fs_reg; ft_next = ft_reg;
        pf_next = pf_reg; bk_next = bk_reg; bs_next = bs_reg; el_next = el_reg;
        offs_next = offs_reg + OFFSET_BITS'(1);
        res_valid = 1'b0;
        res = '0;

        case (phase_reg)
            PH_SIG:
            begin
                if (b != sig_byte(cnt_reg[2:0]) && !(cnt_reg == 10'd4 && b == 8'h39))
                begin
                    res_valid = 1'b1; res.kind = KIND_ERROR; phase_next = PH_DONE;
                end
                else if (cnt_inc >= 10'd6)
                begin
                    phase_next = PH_LSD; cnt_next = '0;
                end
                else cnt_next = cnt_inc;
            end
            PH_LSD:
            begin
                case (cnt_reg[2:0])
                    3'd0: scr_next[7:0]   = b;
                    3'd1: scr_next[15:8]  = b;
                    3'd2: scr_next[23:16] = b;
                    3'd3: scr_next[31:24] = b;
                    3'd4: pf_next = b;
                    3'd5: bgi_next = b;
                    default: ;
                endcase
                cnt_next = cnt_inc;
                if (cnt_inc >= 10'd7)
                begin
                    cnt_next = '0;
                    if (pf_reg[7])
                    begin
                        ctb_next = 10'(10'd3 << ({1'b0, pf_reg[2:0]} + 4'd1));
                        phase_next = PH_GCT;
                    end
                    else
                    begin
                        res_valid = 1'b1; res.kind = KIND_SCREEN;
                        res.width = scr_reg[15:0]; res.height = scr_reg[31:16];
                        res.background_rgb = bgc_reg; phase_next = PH_BLOCK;
                    end
                end
            end
            PH_GCT:
            begin
                // Bytes idx*3 .. idx*3+2 of the table are the background entry.
                if (cnt_reg >= gct_idx3 && cnt_reg < gct_idx3 + 10'd3)
                    bgc_next = {bgc_reg[15:0], b};
                cnt_next = cnt_inc;
                if (cnt_inc >= ctb_reg)
                begin
                    cnt_next = '0; res_valid = 1'b1; res.kind = KIND_SCREEN;
                    res.width = scr_reg[15:0]; res.height = scr_reg[31:16];
                    res.background_rgb = bgc_next; phase_next = PH_BLOCK;
                end
            end
            PH_BLOCK:
            begin
                bs_next = offs_reg;
                if (b == INTRO_EXT) phase_next = PH_LABEL;
                else if (b == INTRO_IMAGE)
                begin
                    if (!pc_reg) fs_next = offs_reg;
                    bk_next = BK_IMAGE; rect_next = '0; cnt_next = '0;
                    phase_next = PH_IMGDESC;
                end
                else if (b == INTRO_TRAILER)
                begin
                    res_valid = 1'b1; res.kind = KIND_END;
                    res.frame_number = 16'(ft_reg); phase_next = PH_DONE;
                end
                else
                begin
                    res_valid = 1'b1; res.kind = KIND_ERROR; phase_next = PH_DONE;
                end
            end
            PH_LABEL:
            begin
                cnt_next = '0;
                if (b == LABEL_CTRL)
                begin
                    bk_next = pc_reg ? BK_CTRL_SKIP : BK_CTRL_KEEP;
                    if (!pc_reg)
                    begin
                        fs_next = bs_reg; pc_next = 1'b1;
                    end
                    el_next = 4'd6; phase_next = PH_EXTHDR;
                end
                else if (b == LABEL_PLAIN)
                begin
                    if (!pc_reg) fs_next = bs_reg;
                    bk_next = BK_PLAIN; el_next = 4'd13; phase_next = PH_EXTHDR;
                end
                else if (b == LABEL_APP)
                begin
                    bk_next = BK_OTHER; el_next = 4'd12; phase_next = PH_EXTHDR;
                end
                else if (b == LABEL_COMMENT)
                begin
                    bk_next = BK_OTHER; phase_next = PH_SUBLEN;
                end
                else
                begin
                    res_valid = 1'b1; res.kind = KIND_ERROR; phase_next = PH_DONE;
                end
            end
            PH_EXTHDR:
            begin
                if (bk_reg == BK_CTRL_KEEP)
                begin
                    if (cnt_reg == 10'd1) pdis_next = b[4:2];
                    else if (cnt_reg == 10'd2) pd_next = {8'd0, b};
                    else if (cnt_reg == 10'd3) pd_next = {b, pd_reg[7:0]};
                end
                cnt_next = cnt_inc;
                if (cnt_inc >= {6'd0, el_reg})
                begin
                    cnt_next = '0;
                    if (bk_reg == BK_CTRL_KEEP || bk_reg == BK_CTRL_SKIP)
                        phase_next = PH_BLOCK;
                    else
                        phase_next = PH_SUBLEN;
                end
            end
            PH_SUBLEN:
            begin
                if (b == 8'd0)
                begin
                    if (bk_reg == BK_IMAGE || bk_reg == BK_PLAIN)
                    begin
                        res_valid = 1'b1; res.kind = KIND_FRAME;
                        res.frame_number = 16'(ft_reg);
                        if (pc_reg)
                        begin
                            res.delay = (pd_reg < min_delay) ? min_delay : pd_reg;
                            res.has_control = 1'b1; res.disposal = pdis_reg;
                        end
                        else res.delay = min_delay;
                        if (bk_reg == BK_IMAGE)
                        begin
                            res.left = rect_reg[15:0];   res.top = rect_reg[31:16];
                            res.width = rect_reg[47:32]; res.height = rect_reg[63:48];
                        end
                        res.span_start  = 24'(fs_reg);
                        res.span_length = 24'(span_len);
                        ft_next = ft_reg + COUNT_BITS'(1);
                        pc_next = 1'b0; pd_next = '0; pdis_next = '0;
                    end
                    phase_next = PH_BLOCK;
                end
                else
                begin
                    cnt_next = {2'd0, b}; phase_next = PH_SUBDATA;
                end
            end
            PH_SUBDATA:
            begin
                if (cnt_reg <= 10'd1)
                begin
                    cnt_next = '0; phase_next = PH_SUBLEN;
                end
                else cnt_next = cnt_reg - 10'd1;
            end
            PH_IMGDESC:
            begin
                if (cnt_reg < 10'd8)
                begin
                    case (cnt_reg[2:0])
                        3'd0: rect_next[7:0]   = b;
                        3'd1: rect_next[15:8]  = b;
                        3'd2: rect_next[23:16] = b;
                        3'd3: rect_next[31:24] = b;
                        3'd4: rect_next[39:32] = b;
                        3'd5: rect_next[47:40] = b;
                        3'd6: rect_next[55:48] = b;
                        default: rect_next[63:56] = b;
                    endcase
                    cnt_next = cnt_inc;
                end
                else
                begin
                    cnt_next = '0;
                    if (b[7])
                    begin
                        ctb_next = tbl_bytes; phase_next = PH_LCT;
                    end
                    else phase_next = PH_LZW;
                end
            end
            PH_LCT:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= ctb_reg)
                begin
                    cnt_next = '0; phase_next = PH_LZW;
                end
            end
            PH_LZW: phase_next = PH_SUBLEN;
            default: ;
        endcase

        // A stream that ends before a trailer or an error is an error.
        if (din.last && phase_next != PH_DONE)
        begin
            res_valid = 1'b1; res = '0; res.kind = KIND_ERROR;
        end
        if (din.last)
        begin
            phase_next = PH_SIG; cnt_next = '0; offs_next = '0; ctb_next = '0;
            bgi_next = '0; bgc_next = '0; scr_next = '0; pc_next = 1'b0;
            pd_next = '0; pdis_next = '0; rect_next = '0; fs_next = '0;
            ft_next = '0; pf_next = '0; bk_next = BK_OTHER; bs_next = '0;
            el_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIG; cnt_reg <= '0; offs_reg <= '0; ctb_reg <= '0;
            bgi_reg <= '0; bgc_reg <= '0; scr_reg <= '0; pc_reg <= 1'b0;
            pd_reg <= '0; pdis_reg <= '0; rect_reg <= '0; fs_reg <= '0;
            ft_reg <= '0; pf_reg <= '0; bk_reg <= BK_OTHER; bs_reg <= '0;
            el_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next; cnt_reg <= cnt_next; offs_reg <= offs_next;
            ctb_reg <= ctb_next; bgi_reg <= bgi_next; bgc_reg <= bgc_next;
            scr_reg <= scr_next; pc_reg <= pc_next; pd_reg <= pd_next;
            pdis_reg <= pdis_next; rect_reg <= rect_next; fs_reg <= fs_next;
            ft_reg <= ft_next; pf_reg <= pf_next; bk_reg <= bk_next;
            bs_reg <= bs_next; el_reg <= el_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/gif_block_walker.sv =====
// ----------------------------------------------------------------------------
// gif_block_walker: GIF block-structure walker.
// Follows a GIF file byte by byte and reports screen info, frames and end.
// ----------------------------------------------------------------------------
// The block takes one byte request per clock cycle unless stalled and answers
// each with at most one result request. The parse state machine advances
// directly on every accepted byte; its result is held in an output register
// backed by a skid stage, so input is accepted in every cycle unless the skid
// stage is full. The sustained rate is therefore one byte per cycle, set only
// by the result channel's readiness. The min_delay register may be written
// whenever the block is idle; it resets to 10 and survives the end of a file.
`default_nettype none
module gif_block_walker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_we,
    input  wire logic [15:0] cfg_wdata,
    gbw_in_if.sink      in_ch,
    gbw_out_if.source   out_ch
);
    import gbw_pkg::*;

    logic [15:0] min_delay_reg;
    logic        can_take;
    logic        step;
    logic        res_valid;
    gbw_out_t    res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) min_delay_reg <= 16'd10;
        else if (cfg_we) min_delay_reg <= cfg_wdata;
    end

    // A byte is taken whenever the skid slot is free for its result.
    assign in_ch.ready = can_take;
    assign step        = in_ch.valid && can_take;

    gbw_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .din       (in_ch.data),
        .min_delay (min_delay_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    gbw_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && res_valid),
        .push_data (res),
        .can_take  (can_take),
        .m         (out_ch)
    );
endmodule
`default_nettype wire

// ===== test/gbw_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbw_checker: result predictor and scoreboard for the GIF block walker.
// Watches the byte and result channels, predicts each result from the bytes
// accepted so far and compares the whole payload with the block's output.
// ----------------------------------------------------------------------------
module gbw_checker
    import gbw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    gbw_in_if.sink      in_mon,
    gbw_out_if.sink     out_mon,
    output int          fail_count,
    output int          pending_count
);

    // Parser state held by the predictor.
    logic [15:0] min_delay_q;
    logic [3:0]  phase;
    logic [15:0] pcount;
    logic [23:0] offset;
    logic [15:0] table_bytes;
    logic [7:0]  bg_index;
    logic [23:0] bg_color;
    logic [31:0] screen_sz;
    logic        ctrl_pending;
    logic [15:0] ctrl_delay;
    logic [2:0]  ctrl_disposal;
    logic [63:0] rect;
    logic [23:0] span_from;
    logic [15:0] frames_seen;
    logic [7:0]  lsd_flags;
    logic [2:0]  blk_kind;
    logic [23:0] blk_start;
    logic [15:0] hdr_len;

    gbw_out_t expected_results[$];
    gbw_out_t res;
    logic     got;

    assign pending_count = expected_results.size();

    function automatic logic [7:0] signature_at(input int idx);
        logic [7:0] s[6];
        s = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61};
        return s[idx];
    endfunction

    task automatic restart_file();
        phase = PH_SIG; pcount = 0; offset = 0; table_bytes = 0;
        bg_index = 0; bg_color = 0; screen_sz = 0; ctrl_pending = 0;
        ctrl_delay = 0; ctrl_disposal = 0; rect = 0; span_from = 0;
        frames_seen = 0; lsd_flags = 0; blk_kind = BK_OTHER; blk_start = 0;
        hdr_len = 0;
    endtask

    task automatic raise_error();
        res = '0; res.kind = KIND_ERROR; got = 1; phase = PH_DONE;
    endtask

    task automatic report_screen();
        res = '0; res.kind = KIND_SCREEN;
        res.width = screen_sz[15:0]; res.height = screen_sz[31:16];
        res.background_rgb = bg_color; got = 1; phase = PH_BLOCK;
    endtask

    task automatic report_frame();
        res = '0; res.kind = KIND_FRAME; res.frame_number = frames_seen;
        if (ctrl_pending)
        begin
            res.delay = (ctrl_delay < min_delay_q) ? min_delay_q : ctrl_delay;
            res.has_control = 1; res.disposal = ctrl_disposal;
        end
        else
            res.delay = min_delay_q;
        if (blk_kind == BK_IMAGE)
        begin
            res.left = rect[15:0]; res.top = rect[31:16];
            res.width = rect[47:32]; res.height = rect[63:48];
        end
        res.span_start = span_from;
        res.span_length = offset - span_from + 24'd1;
        got = 1; frames_seen++;
        ctrl_pending = 0; ctrl_delay = 0; ctrl_disposal = 0; phase = PH_BLOCK;
    endtask

    task automatic walk_byte(input logic [7:0] b);
        case (phase)
            PH_SIG:
            begin
                if (b != signature_at(pcount) && !(pcount == 4 && b == 8'h39))
                    raise_error();
                else
                begin
                    pcount++;
                    if (pcount >= 6)
                    begin
                        phase = PH_LSD; pcount = 0;
                    end
                end
            end
            PH_LSD:
            begin
                if (pcount < 4) screen_sz |= 32'(b) << (8 * pcount);
                else if (pcount == 4) lsd_flags = b;
                else if (pcount == 5) bg_index = b;
                pcount++;
                if (pcount >= 7)
                begin
                    pcount = 0;
                    if (lsd_flags[7])
                    begin
                        table_bytes = 16'(3 << (int'(lsd_flags[2:0]) + 1));
                        phase = PH_GCT;
                    end
                    else
                        report_screen();
                end
            end
            PH_GCT:
            begin
                if (pcount / 3 == bg_index) bg_color = {bg_color[15:0], b};
                pcount = 16'((pcount + 1) & 16'h3FF);
                if (pcount >= table_bytes)
                begin
                    pcount = 0; report_screen();
                end
            end
            PH_BLOCK:
            begin
                blk_start = offset;
                if (b == INTRO_EXT) phase = PH_LABEL;
                else if (b == INTRO_IMAGE)
                begin
                    if (!ctrl_pending) span_from = offset;
                    blk_kind = BK_IMAGE; rect = 0; pcount = 0; phase = PH_IMGDESC;
                end
                else if (b == INTRO_TRAILER)
                begin
                    res = '0; res.kind = KIND_END; res.frame_number = frames_seen;
                    got = 1; phase = PH_DONE;
                end
                else
                    raise_error();
            end
            PH_LABEL:
            begin
                pcount = 0;
                if (b == LABEL_CTRL)
                begin
                    blk_kind = ctrl_pending ? BK_CTRL_SKIP : BK_CTRL_KEEP;
                    if (!ctrl_pending)
                    begin
                        span_from = blk_start; ctrl_pending = 1;
                    end
                    hdr_len = 6; phase = PH_EXTHDR;
                end
                else if (b == LABEL_PLAIN)
                begin
                    if (!ctrl_pending) span_from = blk_start;
                    blk_kind = BK_PLAIN; hdr_len = 13; phase = PH_EXTHDR;
                end
                else if (b == LABEL_APP)
                begin
                    blk_kind = BK_OTHER; hdr_len = 12; phase = PH_EXTHDR;
                end
                else if (b == LABEL_COMMENT)
                begin
                    blk_kind = BK_OTHER; phase = PH_SUBLEN;
                end
                else
                    raise_error();
            end
            PH_EXTHDR:
            begin
                if (blk_kind == BK_CTRL_KEEP)
                begin
                    if (pcount == 1) ctrl_disposal = b[4:2];
                    else if (pcount == 2) ctrl_delay = {8'd0, b};
                    else if (pcount == 3) ctrl_delay[15:8] = b;
                end
                pcount++;
                if (pcount >= hdr_len)
                begin
                    pcount = 0;
                    if (blk_kind == BK_CTRL_KEEP || blk_kind == BK_CTRL_SKIP)
                        phase = PH_BLOCK;
                    else
                        phase = PH_SUBLEN;
                end
            end
            PH_SUBLEN:
            begin
                if (b == 0)
                begin
                    if (blk_kind == BK_IMAGE || blk_kind == BK_PLAIN) report_frame();
                    else phase = PH_BLOCK;
                end
                else
                begin
                    pcount = {8'd0, b}; phase = PH_SUBDATA;
                end
            end
            PH_SUBDATA:
            begin
                if (pcount > 0) pcount--;
                if (pcount == 0) phase = PH_SUBLEN;
            end
            PH_IMGDESC:
            begin
                if (pcount < 8)
                begin
                    rect |= 64'(b) << (8 * pcount); pcount++;
                end
                else
                begin
                    pcount = 0;
                    if (b[7])
                    begin
                        table_bytes = 16'(3 << (int'(b[2:0]) + 1)); phase = PH_LCT;
                    end
                    else
                        phase = PH_LZW;
                end
            end
            PH_LCT:
            begin
                pcount = 16'((pcount + 1) & 16'h3FF);
                if (pcount >= table_bytes)
                begin
                    pcount = 0; phase = PH_LZW;
                end
            end
            PH_LZW: phase = PH_SUBLEN;
            default: ;
        endcase
    endtask

    // Prediction runs on every accepted byte request; comparison on every
    // accepted result request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delay_q = 16'd10;
            restart_file();
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we) min_delay_q = cfg_wdata;
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_mon.data);
                    fail_count++;
                end
                else if (expected_results[0] !== out_mon.data)
                begin
                    $display("%0t: expected %p actual %p", $time,
                             expected_results[0], out_mon.data);
                    fail_count++;
                    void'(expected_results.pop_front());
                end
                else
                    void'(expected_results.pop_front());
            end
            if (in_mon.valid && in_mon.ready)
            begin
                got = 0;
                if (phase != PH_DONE) walk_byte(in_mon.data.data_byte);
                if (in_mon.data.last && phase != PH_DONE) raise_error();
                offset++;
                if (in_mon.data.last) restart_file();
                if (got) expected_results.insert(expected_results.size(), res);
            end
        end
    end

endmodule

// ===== test/tb_gif_block_walker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gif_block_walker: testbench for the GIF block walker.
// Feeds directed and randomly built GIF byte streams with random idling on
// both channels, across several minimum-delay settings; a checker compares
// every result against its own prediction.
// ----------------------------------------------------------------------------
module tb_gif_block_walker;
    import gbw_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          pending_count;

    // Idle percentages for the sender and receiver; the hold-off flag lets
    // the receiver be stopped for a long stretch.
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        recv_hold;
    int          sent_bytes;

    // The file currently being built, byte by byte.
    logic [7:0]  file_bytes[$];

    gbw_in_if  in_ch();
    gbw_out_if out_ch();

    gif_block_walker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    gbw_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_mon        (in_ch.sink),
        .out_mon       (out_ch.sink),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver decides its readiness afresh at every edge; during a
    // hold-off it stays low so that the block backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (recv_hold)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Appends one byte to the file being built.
    task automatic add_byte(input logic [7:0] v);
        file_bytes.insert(file_bytes.size(), v);
    endtask

    // Sends one byte request and waits for it to be accepted. The valid line
    // stays high between back-to-back requests; an idle gap lowers it.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data.data_byte <= b;
        in_ch.data.last      <= is_last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent_bytes++;
    endtask

    // Sends the built file; the final byte carries last when asked.
    task automatic send_file(input logic mark_last);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], mark_last && (i == file_bytes.size() - 1));
        file_bytes.delete();
    endtask

    // Lowers valid, waits until every expected result has arrived and then lets
    // the clock run on for the output register and skid stage to drain.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_min_delay(input logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic add_header(input logic is89, input logic with_table,
                              input logic [2:0] tsize, input logic [7:0] bgi);
        int n;
        add_byte(8'h47); add_byte(8'h49);
        add_byte(8'h46); add_byte(8'h38);
        add_byte(is89 ? 8'h39 : 8'h37); add_byte(8'h61);
        repeat (4) add_byte(8'($urandom));
        add_byte({with_table, 4'($urandom), tsize});
        add_byte(bgi);
        add_byte(8'($urandom));
        n = with_table ? 3 << (int'(tsize) + 1) : 0;
        repeat (n) add_byte(8'($urandom));
    endtask

    task automatic add_subblocks(input int count);
        int len;
        repeat (count)
        begin
            len = ($urandom_range(39) == 0) ? 255 : $urandom_range(1, 6);
            add_byte(8'(len));
            repeat (len) add_byte(8'($urandom));
        end
        add_byte(8'h00);
    endtask

    task automatic add_control();
        add_byte(INTRO_EXT); add_byte(LABEL_CTRL);
        add_byte(8'h04);
        add_byte(8'($urandom));
        add_byte(8'($urandom_range(3) == 0 ? 0 : $urandom));
        add_byte(8'($urandom_range(1) ? 0 : $urandom));
        add_byte(8'($urandom)); add_byte(8'h00);
    endtask

    task automatic add_image(input logic with_table);
        add_byte(INTRO_IMAGE);
        repeat (8) add_byte(8'($urandom));
        add_byte({with_table, 4'($urandom), 3'($urandom_range(2))});
        if (with_table)
            repeat (3 << (int'(file_bytes[$][2:0]) + 1)) add_byte(8'($urandom));
        add_byte(8'($urandom));
        add_subblocks($urandom_range(3));
    endtask

    task automatic add_plain();
        add_byte(INTRO_EXT); add_byte(LABEL_PLAIN);
        repeat (13) add_byte(8'($urandom));
        add_subblocks($urandom_range(2));
    endtask

    task automatic add_other_ext();
        add_byte(INTRO_EXT);
        if ($urandom_range(1))
        begin
            add_byte(LABEL_APP);
            repeat (12) add_byte(8'($urandom));
        end
        else
            add_byte(LABEL_COMMENT);
        add_subblocks($urandom_range(2));
    endtask

    // Builds a random, mostly well-formed file; about one in three is damaged
    // by a stray byte, a cut, a dangling extension or a changed signature byte.
    task automatic build_random_file();
        int blocks;
        add_header($urandom_range(1), $urandom_range(3) != 0,
                   3'($urandom_range(2)), 8'($urandom_range(9)));
        blocks = $urandom_range(1, 3);
        repeat (blocks)
        begin
            case ($urandom_range(5))
                0, 1:
                begin
                    if ($urandom_range(1)) add_control();
                    add_image($urandom_range(4) == 0);
                end
                2:
                begin
                    add_control();
                    if ($urandom_range(1)) add_control();
                    add_plain();
                end
                3: add_plain();
                4: add_other_ext();
                default:
                begin
                    add_control();
                    add_image(1'b0);
                end
            endcase
        end
        case ($urandom_range(11))
            0: add_byte(8'($urandom));
            1: file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 1)];
            2:
            begin
                add_byte(INTRO_EXT);
                add_byte(8'($urandom));
            end
            3: file_bytes[$urandom_range(5)] = 8'($urandom);
            default: add_byte(INTRO_TRAILER);
        endcase
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
    endtask

    initial
    begin
        logic [15:0] delays[5];
        int          budget;
        int          files;
        delays = '{16'd0, 16'hFFFF, 16'd10, 16'd300, 16'd1};
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        recv_hold      = 1'b0;
        send_idle_pct  = 29;
        recv_idle_pct  = 51;
        sent_bytes     = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a full file on the reset delay, using the global table
        // with the background index picking its last entry.
        add_header(1'b1, 1'b1, 3'd0, 8'd1);
        add_control(); add_control(); add_image(1'b1);
        add_plain(); add_other_ext(); add_image(1'b0);
        add_byte(INTRO_TRAILER);
        send_file(1'b1);
        // Background index beyond the table, and bytes after the end.
        add_header(1'b0, 1'b1, 3'd0, 8'd200);
        add_byte(INTRO_TRAILER);
        add_byte(8'hFF);
        send_file(1'b1);
        // Bad signature, bad version, unknown block, unknown label, cut short.
        send_byte(8'h48, 1'b0); send_byte(8'h00, 1'b1);
        send_byte(8'h47, 1'b0); send_byte(8'h49, 1'b0); send_byte(8'h46, 1'b0);
        send_byte(8'h38, 1'b0); send_byte(8'h38, 1'b1);
        add_header(1'b1, 1'b0, 3'd0, 8'd0);
        add_byte(8'h00);
        send_file(1'b1);
        add_header(1'b1, 1'b0, 3'd0, 8'd0);
        add_byte(INTRO_EXT); add_byte(8'h02);
        send_file(1'b1);
        send_byte(8'h47, 1'b1);
        // A control extension left pending at the trailer.
        add_header(1'b0, 1'b0, 3'd0, 8'd0);
        add_control();
        add_byte(INTRO_TRAILER);
        send_file(1'b1);

        // Random files, one idling pattern and delay setting per phase, each
        // phase sending about a hundred bytes.
        for (int p = 0; p < 5; p++)
        begin
            write_min_delay(delays[p]);
            send_idle_pct = (p == 0) ? 29 : (p == 1) ? 51 : 0;
            recv_idle_pct = (p == 0) ? 51 : (p == 1) ? 29 : 0;
            if (p == 3)
            begin
                // Long receiver hold-off while bytes keep coming.
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (200) @(posedge clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            budget = sent_bytes + 100;
            files  = 0;
            while (sent_bytes < budget)
            begin
                build_random_file();
                send_file($urandom_range(9) != 0);
                files++;
                if (files == 1) drain();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/gbw_pkg.sv
sv/gbw_stream_if.sv
sv/gbw_out_reg.sv
sv/gbw_parser.sv
sv/gif_block_walker.sv
test/gbw_checker.sv
test/tb_gif_block_walker.sv
